[hdl/plm_pkg.sv]
// Package with the shared types and codes of the piecewise linear map.
package plm_pkg;

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_EVAL   = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_SAT   = 2'd2,
		STAT_SPARE = 2'd3
	} status_t;

	localparam logic REG_OFFSET = 1'b0;
	localparam logic REG_SCALE  = 1'b1;

	localparam int unsigned DIV_STEPS = 33;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CHK,
		S_INS_PUT,
		S_BS_RD,
		S_BS_CHK,
		S_BS_PRV,
		S_OUT_Y,
		S_MUL_LIN,
		S_MUL_INT,
		S_SAT,
		S_DIV
	} state_t;

endpackage

[hdl/plm_ram.sv]
// Generic single write port RAM with a registered read port.
module plm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/piecewise_linear_map.sv]
// Piecewise linear map over a sorted breakpoint table, Q16.16 arithmetic.
//
// An item is taken when start is high and busy is low. func selects clear,
// insert or evaluate. Exactly one result per item comes on result_value and
// status with done high for one cycle, which the receiver must take then.
// busy is high from the cycle after start and low again in the cycle of done.
// A clear, an unused code or an insert into an empty or full table finishes
// from the idle state and never raises busy. Other inserts read and move each
// larger entry up one place, then write the point. Evaluation on an empty
// table multiplies and saturates, with one point it returns that ordinate,
// otherwise a binary search runs, then, for a point between two entries, the
// multiply and the 33 step restoring divider.
// The breakpoint table is one RAM with one read and one write port; the
// insert shift and the search probes each wait on its registered read.
// offset_b and scale_a come over APB; the user must write them only while the
// block is idle, which it does not enforce. Reset empties the table, zeroes
// offset_b and sets scale_a to one; the RAM, unused past the count, is kept.
module piecewise_linear_map #(
	parameter int MAX_POINTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] query_value,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic [1:0]         status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	plm_pkg::state_t state_q, state_d;

	logic signed [31:0] offset_q, scale_q;
	logic [CW-1:0]      count_q;
	logic signed [31:0] q_q, px_q, py_q;
	logic [AW-1:0]      idx_q;
	logic [CW-1:0]      lo_q, hi_q;
	logic signed [31:0] x2_q, y2_q, y1_q;
	logic               neg_q;
	logic signed [33:0] mul_a_q, mul_b_q;
	logic signed [67:0] prod_q;
	logic [32:0]        dx_q, rem_q, quot_q, dvn_q;
	logic [5:0]         dcnt_q;
	logic               done_q;
	logic signed [31:0] res_q;
	logic [1:0]         stat_q;

	// RAM port
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [63:0]   ram_wdata, ram_rdata;
	logic signed [31:0] rd_x, rd_y;

	plm_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_x = ram_rdata[63:32];
	assign rd_y = ram_rdata[31:0];

	// Configuration port
	logic apb_wr;
	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == plm_pkg::REG_SCALE) ? scale_q : offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			scale_q  <= 32'sd65536;
		end else if (apb_wr) begin
			if (paddr[2] == plm_pkg::REG_SCALE) begin
				scale_q <= pwdata;
			end else begin
				offset_q <= pwdata;
			end
		end
	end

	// Shared datapath helpers
	logic [CW:0]        mid_sum;
	logic [AW-1:0]      mid;
	logic               full;
	logic signed [32:0] dy, tq, dxs;
	logic [32:0]        dy_mag;
	logic [67:0]        prod_mag;
	logic               sat_pos, sat_neg;
	logic [33:0]        trial;
	logic               ge;
	logic [32:0]        quot_d;
	logic signed [33:0] y_sum;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[AW:1];
	assign full    = count_q >= CW'(MAX_POINTS);
	assign dy      = {y2_q[31], y2_q} - {rd_y[31], rd_y};
	assign dy_mag  = dy[32] ? 33'(-dy) : 33'(dy);
	assign tq      = {q_q[31], q_q} - {rd_x[31], rd_x};
	assign dxs     = {x2_q[31], x2_q} - {rd_x[31], rd_x};
	assign prod_mag = prod_q[67] ? 68'(-prod_q) : 68'(prod_q);
	// The scaled product is truncated toward zero by shifting the magnitude.
	assign sat_pos = !prod_q[67] && (prod_mag[67:16] > 52'h7FFFFFFF);
	assign sat_neg = prod_q[67] && (prod_mag[67:16] > 52'h80000000);
	assign trial   = {rem_q, dvn_q[32]};
	assign ge      = trial >= {1'b0, dx_q};
	assign quot_d  = {quot_q[31:0], ge};
	assign y_sum   = neg_q ? ({{2{y1_q[31]}}, y1_q} - {1'b0, quot_d})
	                       : ({{2{y1_q[31]}}, y1_q} + {1'b0, quot_d});

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			plm_pkg::S_IDLE: begin
				if (start) begin
					if (func == plm_pkg::FUNC_INSERT) begin
						if (!full && count_q != '0) begin
							state_d = plm_pkg::S_INS_RD;
						end
					end else if (func == plm_pkg::FUNC_EVAL) begin
						if (count_q == '0) begin
							state_d = plm_pkg::S_MUL_LIN;
						end else if (count_q == CW'(1)) begin
							state_d = plm_pkg::S_OUT_Y;
						end else begin
							state_d = plm_pkg::S_BS_RD;
						end
					end
				end
			end
			plm_pkg::S_INS_RD:  state_d = plm_pkg::S_INS_CHK;
			plm_pkg::S_INS_CHK: begin
				if (rd_x <= px_q) begin
					state_d = plm_pkg::S_IDLE;
				end else if (idx_q == '0) begin
					state_d = plm_pkg::S_INS_PUT;
				end else begin
					state_d = plm_pkg::S_INS_RD;
				end
			end
			plm_pkg::S_INS_PUT: state_d = plm_pkg::S_IDLE;
			plm_pkg::S_BS_RD: begin
				state_d = (lo_q > hi_q) ? plm_pkg::S_OUT_Y : plm_pkg::S_BS_CHK;
			end
			plm_pkg::S_BS_CHK: begin
				if (rd_x < q_q) begin
					state_d = plm_pkg::S_BS_RD;
				end else if (idx_q == '0) begin
					state_d = plm_pkg::S_OUT_Y;
				end else begin
					state_d = plm_pkg::S_BS_PRV;
				end
			end
			plm_pkg::S_BS_PRV: begin
				if (rd_x > q_q) begin
					state_d = plm_pkg::S_BS_RD;
				end else if (rd_x == x2_q) begin
					state_d = plm_pkg::S_IDLE;
				end else begin
					state_d = plm_pkg::S_MUL_INT;
				end
			end
			plm_pkg::S_OUT_Y:   state_d = plm_pkg::S_IDLE;
			plm_pkg::S_MUL_LIN: state_d = plm_pkg::S_SAT;
			plm_pkg::S_SAT:     state_d = plm_pkg::S_IDLE;
			plm_pkg::S_MUL_INT: state_d = plm_pkg::S_DIV;
			plm_pkg::S_DIV: begin
				if (dcnt_q == 6'd1) begin
					state_d = plm_pkg::S_IDLE;
				end
			end
			default: state_d = plm_pkg::S_IDLE;
		endcase
	end

	// RAM control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = {px_q, py_q};
		ram_raddr = '0;
		unique case (state_q)
			plm_pkg::S_IDLE: begin
				ram_wdata = {point_x, point_y};
				ram_we = start && (func == plm_pkg::FUNC_INSERT) && !full
				         && (count_q == '0);
			end
			plm_pkg::S_INS_RD: ram_raddr = idx_q;
			plm_pkg::S_INS_CHK: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q + AW'(1);
				if (rd_x > px_q) begin
					ram_wdata = ram_rdata;
				end
			end
			plm_pkg::S_INS_PUT: ram_we = 1'b1;
			plm_pkg::S_BS_RD: begin
				ram_raddr = (lo_q > hi_q) ? AW'(count_q - CW'(1)) : mid;
			end
			plm_pkg::S_BS_CHK: begin
				// A hit on the first entry goes back for its ordinate.
				ram_raddr = (idx_q == '0) ? '0 : idx_q - AW'(1);
			end
			default: ram_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plm_pkg::S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				plm_pkg::S_IDLE: begin
					if (start) begin
						if (func == plm_pkg::FUNC_CLEAR) begin
							count_q <= '0;
						end
						if (func == plm_pkg::FUNC_INSERT && !full && count_q == '0) begin
							count_q <= CW'(1);
						end
					end
					done_q <= start && ((func == plm_pkg::FUNC_CLEAR)
					          || (func == plm_pkg::FUNC_NONE)
					          || (func == plm_pkg::FUNC_INSERT && (full || count_q == '0)));
				end
				plm_pkg::S_INS_CHK: begin
					if (rd_x <= px_q) begin
						count_q <= count_q + CW'(1);
					end
					done_q <= (rd_x <= px_q);
				end
				plm_pkg::S_INS_PUT: begin
					count_q <= count_q + CW'(1);
					done_q  <= 1'b1;
				end
				plm_pkg::S_BS_PRV: done_q <= (rd_x <= q_q) && (rd_x == x2_q);
				plm_pkg::S_OUT_Y:  done_q <= 1'b1;
				plm_pkg::S_SAT:    done_q <= 1'b1;
				plm_pkg::S_DIV:    done_q <= (dcnt_q == 6'd1);
				default: done_q <= 1'b0;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			plm_pkg::S_IDLE: begin
				q_q    <= query_value;
				px_q   <= point_x;
				py_q   <= point_y;
				idx_q  <= AW'(count_q - CW'(1));
				lo_q   <= '0;
				hi_q   <= count_q - CW'(1);
				res_q  <= '0;
				stat_q <= (func == plm_pkg::FUNC_INSERT && full) ? plm_pkg::STAT_FULL
				                                                 : plm_pkg::STAT_OK;
				mul_a_q <= {{2{query_value[31]}}, query_value}
				           - {{2{offset_q[31]}}, offset_q};
				mul_b_q <= {{2{scale_q[31]}}, scale_q};
			end
			plm_pkg::S_INS_CHK: begin
				idx_q <= idx_q - AW'(1);
			end
			plm_pkg::S_BS_RD: idx_q <= (lo_q > hi_q) ? AW'(count_q - CW'(1)) : mid;
			plm_pkg::S_BS_CHK: begin
				x2_q <= rd_x;
				y2_q <= rd_y;
				if (rd_x < q_q) begin
					lo_q <= CW'(idx_q) + CW'(1);
				end
			end
			plm_pkg::S_BS_PRV: begin
				y1_q  <= rd_y;
				res_q <= rd_y;
				if (rd_x > q_q) begin
					hi_q <= CW'(idx_q) - CW'(1);
				end
				neg_q   <= dy[32];
				dx_q    <= 33'(dxs);
				mul_a_q <= {1'b0, dy_mag};
				mul_b_q <= {1'b0, tq};
			end
			plm_pkg::S_OUT_Y: res_q <= rd_y;
			plm_pkg::S_MUL_LIN: prod_q <= mul_a_q * mul_b_q;
			plm_pkg::S_MUL_INT: begin
				prod_q <= mul_a_q * mul_b_q;
				dcnt_q <= 6'(plm_pkg::DIV_STEPS + 1);
			end
			plm_pkg::S_SAT: begin
				if (sat_pos) begin
					res_q  <= 32'sh7FFFFFFF;
					stat_q <= plm_pkg::STAT_SAT;
				end else if (sat_neg) begin
					res_q  <= 32'sh80000000;
					stat_q <= plm_pkg::STAT_SAT;
				end else begin
					res_q <= prod_q[67] ? -prod_mag[47:16] : prod_mag[47:16];
				end
			end
			plm_pkg::S_DIV: begin
				if (dcnt_q == 6'(plm_pkg::DIV_STEPS + 1)) begin
					// The product is nonnegative here; its top bits already lie below the divisor.
					rem_q  <= prod_q[65:33];
					dvn_q  <= prod_q[32:0];
					quot_q <= '0;
					dcnt_q <= 6'(plm_pkg::DIV_STEPS);
				end else begin
					rem_q  <= ge ? 33'(trial - {1'b0, dx_q}) : trial[32:0];
					quot_q <= quot_d;
					dvn_q  <= {dvn_q[31:0], 1'b0};
					dcnt_q <= dcnt_q - 6'd1;
					res_q  <= y_sum[31:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign busy         = state_q != plm_pkg::S_IDLE;
	assign done         = done_q;
	assign result_value = res_q;
	assign status       = stat_q;

endmodule

[tb/tb_piecewise_linear_map.sv]
// Self-checking testbench for the piecewise linear map block.
`timescale 1ns / 1ps

module tb_piecewise_linear_map;

	localparam int TABLE_DEPTH = 64;
	localparam int STALL_LIMIT = 4000;
	localparam logic [2:0] ADDR_OFFSET = 3'(4 * plm_pkg::REG_OFFSET);
	localparam logic [2:0] ADDR_SCALE  = 3'(4 * plm_pkg::REG_SCALE);

	typedef struct packed {
		logic signed [31:0] value;
		plm_pkg::status_t   stat;
	} map_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         func;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] query_value;
	logic               done;
	logic signed [31:0] result_value;
	logic [1:0]         status;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	// Shadow of the block's table and registers.
	logic signed [31:0] knot_x [TABLE_DEPTH];
	logic signed [31:0] knot_y [TABLE_DEPTH];
	int                 knot_count;
	logic signed [31:0] cur_offset;
	logic signed [31:0] cur_scale;

	map_result_t pending_results[$];
	int          idle_pct;
	int          error_count;
	int          items_sent;
	int          results_seen;
	int          stall_cycles;
	int          sat_seen;
	int          full_seen;

	piecewise_linear_map #(.MAX_POINTS(TABLE_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.point_x(point_x), .point_y(point_y), .query_value(query_value),
		.done(done), .result_value(result_value), .status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic map_result_t lookup_value(logic signed [31:0] q);
		map_result_t r;
		longint      prod;
		longint      scaled;
		int          lo;
		int          hi;
		int          c;
		int          hit;
		longint      dy;
		logic [63:0] t;
		logic [63:0] dx;
		logic [63:0] step;
		r.stat = plm_pkg::STAT_OK;
		if (knot_count == 0) begin
			prod = (longint'(q) - longint'(cur_offset)) * longint'(cur_scale);
			scaled = prod < 0 ? -((-prod) >>> 16) : prod >>> 16;
			if (scaled > 64'sd2147483647) begin
				scaled = 64'sd2147483647;
				r.stat = plm_pkg::STAT_SAT;
			end else if (scaled < -64'sd2147483648) begin
				scaled = -64'sd2147483648;
				r.stat = plm_pkg::STAT_SAT;
			end
			r.value = scaled[31:0];
			return r;
		end
		if (knot_count == 1) begin
			r.value = knot_y[0];
			return r;
		end
		lo = 0;
		hi = knot_count - 1;
		hit = -1;
		while (lo <= hi) begin
			c = (lo + hi) / 2;
			if (knot_x[c] < q) begin
				lo = c + 1;
			end else if (c == 0 || knot_x[c - 1] <= q) begin
				hit = c;
				break;
			end else begin
				hi = c - 1;
			end
		end
		if (hit < 0) begin
			r.value = knot_y[knot_count - 1];
		end else if (hit == 0 || knot_x[hit - 1] == knot_x[hit]) begin
			r.value = knot_y[hit == 0 ? 0 : hit - 1];
		end else begin
			dy = longint'(knot_y[hit]) - longint'(knot_y[hit - 1]);
			t = 64'(longint'(q) - longint'(knot_x[hit - 1]));
			dx = 64'(longint'(knot_x[hit]) - longint'(knot_x[hit - 1]));
			step = 64'(dy < 0 ? -dy : dy) * t / dx;
			r.value = dy < 0 ? knot_y[hit - 1] - 32'(step) : knot_y[hit - 1] + 32'(step);
		end
		return r;
	endfunction

	// Updates the shadow table and returns the result the block must give.
	function automatic map_result_t apply_item(plm_pkg::func_t f, logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] q);
		map_result_t r;
		int          pos;
		r.value = '0;
		r.stat = plm_pkg::STAT_OK;
		case (f)
			plm_pkg::FUNC_CLEAR: knot_count = 0;
			plm_pkg::FUNC_INSERT: begin
				if (knot_count >= TABLE_DEPTH) begin
					r.stat = plm_pkg::STAT_FULL;
				end else begin
					pos = 0;
					while (pos < knot_count && knot_x[pos] <= px)
						pos++;
					for (int i = knot_count; i > pos; i--) begin
						knot_x[i] = knot_x[i - 1];
						knot_y[i] = knot_y[i - 1];
					end
					knot_x[pos] = px;
					knot_y[pos] = py;
					knot_count++;
				end
			end
			plm_pkg::FUNC_EVAL: r = lookup_value(q);
			default: ;
		endcase
		return r;
	endfunction

	// Sends one item; entered and left at a falling edge, and left with start held high.
	task automatic send_item(plm_pkg::func_t f, logic signed [31:0] px = '0,
			logic signed [31:0] py = '0, logic signed [31:0] q = '0);
		map_result_t r;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		start <= 1'b1;
		func <= f;
		point_x <= px;
		point_y <= py;
		query_value <= q;
		do @(posedge clk); while (busy);
		r = apply_item(f, px, py, q);
		if (r.stat == plm_pkg::STAT_SAT)
			sat_seen++;
		if (r.stat == plm_pkg::STAT_FULL)
			full_seen++;
		pending_results.push_back(r);
		items_sent++;
		stall_cycles = 0;
		@(negedge clk);
	endtask

	// Lets every expected result arrive and leaves the block idle.
	task automatic drain;
		start <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		psel <= 1'b1;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== data) begin
			$error("register %0d readback: expected %h, got %h", addr, data, prdata);
			error_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_OFFSET)
			cur_offset = data;
		else
			cur_scale = data;
	endtask

	task automatic set_linear(logic [31:0] offs, logic [31:0] scl);
		drain();
		write_reg(ADDR_OFFSET, offs);
		write_reg(ADDR_SCALE, scl);
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return 32'(int'($urandom_range(0, 16)) - 8) <<< 16;
			2: return 32'(int'($urandom_range(0, 2000)) - 1000);
			default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_query();
		int k;
		if (knot_count == 0 || $urandom_range(3) == 0)
			return rand_coord();
		k = $urandom_range(knot_count - 1);
		return knot_x[k] + 32'(int'($urandom_range(0, 6)) - 3);
	endfunction

	task automatic test_reset_linear;
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'h0001_8000);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'h7fff_ffff);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'h8000_0000);
		send_item(plm_pkg::FUNC_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
	endtask

	task automatic test_linear_extremes;
		set_linear(32'h8000_0000, 32'h7fff_ffff);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'h7fff_ffff);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'h8000_0000);
		set_linear(32'h7fff_ffff, 32'h8000_0000);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'h8000_0000);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'h7fff_fffe);
		set_linear(32'hffff_0000, 32'hfffe_8000);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'h0003_0001);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'hfff0_0003);
	endtask

	task automatic test_table_lookup;
		send_item(plm_pkg::FUNC_CLEAR);
		send_item(plm_pkg::FUNC_INSERT, 32'h0001_0000, 32'h0005_0000);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'h8000_0000);
		send_item(plm_pkg::FUNC_INSERT, 32'h8000_0000, 32'h7fff_ffff);
		send_item(plm_pkg::FUNC_INSERT, 32'h7fff_ffff, 32'h8000_0000);
		send_item(plm_pkg::FUNC_INSERT, 32'h0001_0000, 32'hffff_0000);
		send_item(plm_pkg::FUNC_INSERT, 32'h0004_0000, 32'h0002_0000);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'h8000_0000);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'h7fff_ffff);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'h0001_0000);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'h0002_8001);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'h0000_0003);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'h4000_0000);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'hc000_0000);
		send_item(plm_pkg::FUNC_CLEAR);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, 32'h0001_0000);
	endtask

	task automatic test_full_table;
		send_item(plm_pkg::FUNC_CLEAR);
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_item(plm_pkg::FUNC_INSERT, rand_coord(), $urandom());
		send_item(plm_pkg::FUNC_INSERT, 32'h0, 32'h1234_5678);
		send_item(plm_pkg::FUNC_EVAL, '0, '0, rand_query());
		send_item(plm_pkg::FUNC_EVAL, '0, '0, rand_query());
	endtask

	// Mostly clear, fill and query sequences, with stray codes mixed in.
	task automatic test_random(int n_items);
		int sent;
		int n_points;
		int n_evals;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				send_item(plm_pkg::func_t'($urandom_range(3)), $urandom(), $urandom(),
					$urandom());
				sent++;
				continue;
			end
			send_item(plm_pkg::FUNC_CLEAR);
			n_points = $urandom_range(9) == 0 ? $urandom_range(60, 70) : $urandom_range(0, 8);
			for (int i = 0; i < n_points; i++)
				send_item(plm_pkg::FUNC_INSERT, rand_coord(), $urandom());
			n_evals = $urandom_range(3, 12);
			for (int i = n_evals; i > 0; i--)
				send_item(plm_pkg::FUNC_EVAL, '0, '0, rand_query());
			sent += 1 + n_points + n_evals;
		end
	endtask

	always @(posedge clk) begin
		map_result_t exp_r;
		if (done) begin
			results_seen++;
			stall_cycles = 0;
			if (pending_results.size() == 0) begin
				$error("result %h/%0d with no item outstanding", result_value, status);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (result_value !== exp_r.value) begin
					$error("result_value: expected %h, got %h", exp_r.value, result_value);
					error_count++;
				end
				if (status !== exp_r.stat) begin
					$error("status: expected %0d, got %0d", exp_r.stat, status);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			stall_cycles++;
			if (psel)
				stall_cycles = 0;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout with %0d results outstanding", pending_results.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		func = plm_pkg::FUNC_CLEAR;
		point_x = '0;
		point_y = '0;
		query_value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		knot_count = 0;
		cur_offset = '0;
		cur_scale = 32'h0001_0000;
		idle_pct = 34;
		error_count = 0;
		items_sent = 0;
		results_seen = 0;
		stall_cycles = 0;
		sat_seen = 0;
		full_seen = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_linear();
		test_linear_extremes();
		test_table_lookup();
		test_full_table();
		// The sender holds off here until the block has returned everything.
		set_linear($urandom(), $urandom());
		test_random(270);
		idle_pct = 62;
		set_linear($urandom(), 32'($urandom_range(0, 262144)) - 32'd131072);
		test_random(270);
		idle_pct = 0;
		set_linear(32'h0, 32'h0001_0000);
		test_random(270);
		drain();

		$display("Ran %0d transfers, %0d results checked: linear mode at register extremes,",
			items_sent, results_seen);
		$display("table fill past capacity (%0d rejects), lookups, %0d saturations.",
			full_seen, sat_seen);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/plm_pkg.sv
hdl/plm_ram.sv
hdl/piecewise_linear_map.sv
tb/tb_piecewise_linear_map.sv
